[rtl/dcp_pkg.sv]
// dcp_pkg: shared types, constants and control codes for the delta-correlating prefetcher.
// No dependencies.
`timescale 1ns / 1ps
package dcp_pkg;

  localparam int AW = 48;
  localparam int DW = 16;
  localparam int BLOCK_BYTES = 64;
  localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
  localparam int BLKW = AW - BLK_SHIFT;
  localparam int MAX_CAND = 16;
  localparam int CANDW = $clog2(MAX_CAND);
  localparam int NCW = $clog2(MAX_CAND + 1);
  localparam int DEGW = 4;
  localparam int DELTA_BIAS = 32768;

  localparam int TABLE_ENTRIES_DEF = 128;
  localparam int DELTAS_PER_ENTRY_DEF = 16;
  localparam int FILTER_DEPTH_DEF = 16;

  localparam int CFG_IDXW = 1;
  localparam logic [CFG_IDXW-1:0] REG_SEQ_DEGREE = 1'b0;
  localparam logic [CFG_IDXW-1:0] REG_MAX_ADDRESS = 1'b1;

  typedef struct packed {
    logic          opcode;
    logic [AW-1:0] instruction_address;
    logic [AW-1:0] access_address;
  } item_t;

  typedef struct packed {
    logic          prefetch_valid;
    logic [AW-1:0] prefetch_address;
    logic          last_of_run;
  } result_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DISP, ST_COMPL, ST_SRD, ST_SCMP, ST_MISS, ST_HIT, ST_CHK,
    ST_CRD, ST_CCMP, ST_RRD, ST_RSTEP, ST_POST, ST_ISSUE, ST_SEQ, ST_WB_FIN
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_COMPL, OP_SCMP, OP_MISS, OP_HIT, OP_CINIT, OP_CRD,
    OP_CCMP, OP_RRD, OP_RSTEP, OP_ISSUE, OP_SEQ, OP_WB_FIN
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_compl;
    logic srch_hit;
    logic srch_last;
    logic cnt_ge3;
    logic cr_match;
    logic cr_more;
    logic rp_stop;
    logic rp_done;
    logic nc_zero;
    logic last_cand;
    logic seq_stop;
  } dp_sts_t;

endpackage

[rtl/delta_correlating_prefetcher_top.sv]
// delta_correlating_prefetcher_top: top level of the delta-correlating prefetcher.
// Depends on dcp_pkg, dcp_ctrl, dcp_datapath (and dcp_ram below it).
`timescale 1ns / 1ps
// An item is taken when start is high and busy is low; busy then stays high until the
// item's last result beat has been launched. Results come one beat per result_strobe
// pulse, with last_of_run on the final one, and cannot be held off. A completion passes
// through dispatch, the completion step and the final write-back. A demand access walks
// the PC table one entry at a time through the table RAM's single read port, then reads
// the delta history RAM one delta at a time for the pair search and the replay, then
// spends one cycle per candidate or sequential block. A PC found early in the table
// costs much less than a miss.
module delta_correlating_prefetcher_top #(
  parameter int TABLE_ENTRIES = dcp_pkg::TABLE_ENTRIES_DEF,
  parameter int DELTAS_PER_ENTRY = dcp_pkg::DELTAS_PER_ENTRY_DEF,
  parameter int FILTER_DEPTH = dcp_pkg::FILTER_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  dcp_pkg::item_t               item,
  output dcp_pkg::result_t             result,
  output logic                         result_strobe,
  input  logic                         cfg_we,
  input  logic [dcp_pkg::CFG_IDXW-1:0] cfg_index,
  input  logic [dcp_pkg::AW-1:0]       cfg_data
);

  dcp_pkg::dp_cmd_t cmd;
  dcp_pkg::dp_sts_t sts;

  dcp_ctrl u_ctrl (
    .clk(clk), .rst(rst), .start(start), .sts(sts), .busy(busy), .cmd(cmd)
  );

  dcp_datapath #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .DELTAS_PER_ENTRY(DELTAS_PER_ENTRY),
    .FILTER_DEPTH(FILTER_DEPTH)
  ) u_datapath (
    .clk(clk), .rst(rst), .item(item), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .cmd(cmd), .sts(sts), .result(result),
    .result_strobe(result_strobe)
  );

endmodule

[rtl/dcp_ram.sv]
// dcp_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dcp_ctrl.sv]
// dcp_ctrl: sequencing state machine of the prefetcher.
// Depends on dcp_pkg; drives dcp_datapath through dp_cmd_t / dp_sts_t.
`timescale 1ns / 1ps
module dcp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  dcp_pkg::dp_sts_t sts,
  output logic            busy,
  output dcp_pkg::dp_cmd_t cmd
);

  dcp_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dcp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dcp_pkg::ST_IDLE:  if (start) state_next = dcp_pkg::ST_DISP;
      dcp_pkg::ST_DISP:  state_next = sts.is_compl ? dcp_pkg::ST_COMPL : dcp_pkg::ST_SRD;
      dcp_pkg::ST_COMPL: state_next = dcp_pkg::ST_WB_FIN;
      dcp_pkg::ST_SRD:   state_next = dcp_pkg::ST_SCMP;
      dcp_pkg::ST_SCMP: begin
        if (sts.srch_hit) state_next = dcp_pkg::ST_HIT;
        else if (sts.srch_last) state_next = dcp_pkg::ST_MISS;
        else state_next = dcp_pkg::ST_SRD;
      end
      dcp_pkg::ST_MISS:  state_next = dcp_pkg::ST_SEQ;
      dcp_pkg::ST_HIT:   state_next = dcp_pkg::ST_CHK;
      dcp_pkg::ST_CHK:   state_next = sts.cnt_ge3 ? dcp_pkg::ST_CRD : dcp_pkg::ST_SEQ;
      dcp_pkg::ST_CRD:   state_next = dcp_pkg::ST_CCMP;
      dcp_pkg::ST_CCMP: begin
        if (sts.cr_match) state_next = dcp_pkg::ST_RRD;
        else if (sts.cr_more) state_next = dcp_pkg::ST_CRD;
        else state_next = dcp_pkg::ST_SEQ;
      end
      dcp_pkg::ST_RRD:   state_next = dcp_pkg::ST_RSTEP;
      dcp_pkg::ST_RSTEP: begin
        state_next = (sts.rp_stop || sts.rp_done) ? dcp_pkg::ST_POST : dcp_pkg::ST_RRD;
      end
      dcp_pkg::ST_POST:  state_next = sts.nc_zero ? dcp_pkg::ST_SEQ : dcp_pkg::ST_ISSUE;
      dcp_pkg::ST_ISSUE: if (sts.last_cand) state_next = dcp_pkg::ST_WB_FIN;
      dcp_pkg::ST_SEQ:   if (sts.seq_stop) state_next = dcp_pkg::ST_WB_FIN;
      dcp_pkg::ST_WB_FIN: state_next = dcp_pkg::ST_IDLE;
      default:           state_next = dcp_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy   = (state != dcp_pkg::ST_IDLE);
    cmd.op = dcp_pkg::OP_NONE;
    unique case (state)
      dcp_pkg::ST_IDLE:   if (start) cmd.op = dcp_pkg::OP_LOAD;
      dcp_pkg::ST_DISP:   cmd.op = dcp_pkg::OP_NONE;
      dcp_pkg::ST_COMPL:  cmd.op = dcp_pkg::OP_COMPL;
      dcp_pkg::ST_SRD:    cmd.op = dcp_pkg::OP_NONE;
      dcp_pkg::ST_SCMP:   cmd.op = dcp_pkg::OP_SCMP;
      dcp_pkg::ST_MISS:   cmd.op = dcp_pkg::OP_MISS;
      dcp_pkg::ST_HIT:    cmd.op = dcp_pkg::OP_HIT;
      dcp_pkg::ST_CHK:    cmd.op = dcp_pkg::OP_CINIT;
      dcp_pkg::ST_CRD:    cmd.op = dcp_pkg::OP_CRD;
      dcp_pkg::ST_CCMP:   cmd.op = dcp_pkg::OP_CCMP;
      dcp_pkg::ST_RRD:    cmd.op = dcp_pkg::OP_RRD;
      dcp_pkg::ST_RSTEP:  cmd.op = dcp_pkg::OP_RSTEP;
      dcp_pkg::ST_POST:   cmd.op = dcp_pkg::OP_NONE;
      dcp_pkg::ST_ISSUE:  cmd.op = dcp_pkg::OP_ISSUE;
      dcp_pkg::ST_SEQ:    cmd.op = dcp_pkg::OP_SEQ;
      dcp_pkg::ST_WB_FIN: cmd.op = dcp_pkg::OP_WB_FIN;
      default:            cmd.op = dcp_pkg::OP_NONE;
    endcase
  end

endmodule

[rtl/dcp_datapath.sv]
// dcp_datapath: PC table, delta history, candidate list, filter queue and result register.
// Depends on dcp_pkg and dcp_ram; commanded by dcp_ctrl.
`timescale 1ns / 1ps
module dcp_datapath #(
  parameter int TABLE_ENTRIES = dcp_pkg::TABLE_ENTRIES_DEF,
  parameter int DELTAS_PER_ENTRY = dcp_pkg::DELTAS_PER_ENTRY_DEF,
  parameter int FILTER_DEPTH = dcp_pkg::FILTER_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  dcp_pkg::item_t                item,
  input  logic                          cfg_we,
  input  logic [dcp_pkg::CFG_IDXW-1:0]  cfg_index,
  input  logic [dcp_pkg::AW-1:0]        cfg_data,
  input  dcp_pkg::dp_cmd_t              cmd,
  output dcp_pkg::dp_sts_t              sts,
  output dcp_pkg::result_t              result,
  output logic                          result_strobe
);

  localparam int AW = dcp_pkg::AW;
  localparam int BS = dcp_pkg::BLK_SHIFT;
  localparam int EW = $clog2(TABLE_ENTRIES);
  localparam int WPW = $clog2(DELTAS_PER_ENTRY);
  localparam int CNTW = $clog2(DELTAS_PER_ENTRY + 1);
  localparam int FCW = $clog2(FILTER_DEPTH + 1);
  localparam int FIW = (FILTER_DEPTH > 1) ? $clog2(FILTER_DEPTH) : 1;
  localparam int HAW = EW + WPW;
  localparam int REC_W = 3 * AW + WPW + CNTW;
  localparam int NCW = dcp_pkg::NCW;
  localparam int CANDW = dcp_pkg::CANDW;

  dcp_pkg::item_t item_q;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [EW-1:0] rp, eidx, idx;
  logic [AW-1:0] rec_tag, rec_last, rec_lpf;
  logic [WPW-1:0] rec_wp;
  logic [CNTW-1:0] rec_cnt, k;
  logic [dcp_pkg::DW-1:0] d1, d2, prev;
  logic [AW-1:0] ra, p, pend_a;
  logic [AW-1:0] cand [dcp_pkg::MAX_CAND];
  logic [NCW-1:0] nc;
  logic [CANDW-1:0] ci;
  logic [dcp_pkg::DEGW-1:0] sk, seq_degree;
  logic [AW-1:0] max_addr;
  logic [dcp_pkg::BLKW-1:0] filt [FILTER_DEPTH];
  logic [FCW-1:0] fcnt;
  logic pend_v;

  logic [REC_W-1:0] e_rd, e_wd;
  logic e_we;
  logic [AW-1:0] ent_tag, ent_last, ent_lpf;
  logic [WPW-1:0] ent_wp;
  logic [CNTW-1:0] ent_cnt;
  logic h_we;
  logic [HAW-1:0] h_waddr, h_raddr;
  logic [dcp_pkg::DW-1:0] h_rd;

  logic [CNTW-1:0] age_a;
  logic [WPW+1:0] age_t, age_t2;
  logic [AW-1:0] diff, biased;
  logic in_range;
  logic [WPW-1:0] wp_inc;
  logic [16:0] mag;
  logic [AW:0] sum_r, seq_sum;
  logic [AW-1:0] r_new, seq_new, c_cur;
  logic dup;
  logic rp_stop, seq_stop;
  logic [dcp_pkg::BLKW-1:0] chk_blk, rm_blk, ins_blk;
  logic f_hit, rm_found, rm_en, ins_en;
  logic [FIW-1:0] rm_idx;
  logic iss_ok, seq_ok, emit_en;
  logic [AW-1:0] emit_addr;

  dcp_ram #(.WIDTH(REC_W), .DEPTH(TABLE_ENTRIES)) u_entry_ram (
    .clk(clk), .we(e_we), .waddr(eidx), .wdata(e_wd), .raddr(idx), .rdata(e_rd)
  );

  dcp_ram #(.WIDTH(dcp_pkg::DW), .DEPTH(TABLE_ENTRIES << WPW)) u_hist_ram (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(diff[dcp_pkg::DW-1:0]),
    .raddr(h_raddr), .rdata(h_rd)
  );

  assign ent_tag  = e_rd[REC_W-1 -: AW];
  assign ent_last = e_rd[REC_W-AW-1 -: AW];
  assign ent_lpf  = e_rd[REC_W-2*AW-1 -: AW];
  assign ent_wp   = e_rd[CNTW +: WPW];
  assign ent_cnt  = e_rd[CNTW-1:0];
  assign e_wd     = {rec_tag, rec_last, rec_lpf, rec_wp, rec_cnt};
  assign e_we     = (cmd.op == dcp_pkg::OP_WB_FIN) && !item_q.opcode;

  // ring position of a delta by age, newest first
  always_comb begin
    age_a  = (cmd.op == dcp_pkg::OP_RRD) ? k - CNTW'(1) : k;
    age_t  = {2'b00, rec_wp} + (WPW+2)'(DELTAS_PER_ENTRY - 1) - (WPW+2)'(age_a);
    age_t2 = (age_t >= (WPW+2)'(DELTAS_PER_ENTRY)) ?
             age_t - (WPW+2)'(DELTAS_PER_ENTRY) : age_t;
  end
  assign h_raddr = {eidx, age_t2[WPW-1:0]};
  assign h_waddr = {eidx, rec_wp};

  always_comb begin
    diff     = item_q.access_address - rec_last;
    biased   = diff + AW'(dcp_pkg::DELTA_BIAS);
    in_range = (biased[AW-1:dcp_pkg::DW] == '0);
    h_we     = (cmd.op == dcp_pkg::OP_HIT) && (diff != '0) && in_range;
    wp_inc   = (rec_wp == WPW'(DELTAS_PER_ENTRY - 1)) ? '0 : rec_wp + WPW'(1);
  end

  // replay step
  always_comb begin
    mag   = 17'h10000 - {1'b0, h_rd};
    sum_r = {1'b0, ra} + (AW+1)'(h_rd);
    if (h_rd[dcp_pkg::DW-1]) begin
      rp_stop = ((AW)'(mag) >= ra);
      r_new   = ra - (AW)'(mag);
    end else begin
      rp_stop = sum_r[AW];
      r_new   = sum_r[AW-1:0];
    end
    dup = 1'b0;
    for (int x = 0; x < dcp_pkg::MAX_CAND; x++) begin
      if ((NCW'(x) < nc) && (cand[x][AW-1:BS] == r_new[AW-1:BS])) dup = 1'b1;
    end
  end

  // filter lookup and removal search
  always_comb begin
    c_cur   = cand[ci];
    seq_sum = {1'b0, p} + (AW+1)'(dcp_pkg::BLOCK_BYTES);
    seq_new = seq_sum[AW-1:0];
    chk_blk = (cmd.op == dcp_pkg::OP_ISSUE) ? c_cur[AW-1:BS] : seq_new[AW-1:BS];
    rm_blk  = item_q.access_address[AW-1:BS];
    f_hit    = 1'b0;
    rm_found = 1'b0;
    rm_idx   = '0;
    for (int j = FILTER_DEPTH - 1; j >= 0; j--) begin
      if ((FCW'(j) < fcnt) && (filt[j] == chk_blk)) f_hit = 1'b1;
      if ((FCW'(j) < fcnt) && (filt[j] == rm_blk)) begin
        rm_found = 1'b1;
        rm_idx   = FIW'(j);
      end
    end
    seq_stop = (sk >= seq_degree) || seq_sum[AW];
    iss_ok = (c_cur <= max_addr) && !f_hit && (c_cur != rec_lpf);
    seq_ok = (seq_new <= max_addr) && !f_hit;
    emit_en = 1'b0;
    emit_addr = c_cur;
    if (cmd.op == dcp_pkg::OP_ISSUE) begin
      emit_en = iss_ok;
    end else if (cmd.op == dcp_pkg::OP_SEQ) begin
      emit_en   = !seq_stop && seq_ok;
      emit_addr = seq_new;
    end
    ins_en  = emit_en;
    ins_blk = emit_addr[AW-1:BS];
    rm_en   = (cmd.op == dcp_pkg::OP_COMPL) && rm_found;
  end

  always_comb begin
    sts.is_compl  = item_q.opcode;
    sts.srch_hit  = valid[idx] && (ent_tag == item_q.instruction_address);
    sts.srch_last = (idx == EW'(TABLE_ENTRIES - 1));
    sts.cnt_ge3   = (rec_cnt >= CNTW'(3));
    sts.cr_match  = (k >= CNTW'(2)) && (prev == d1) && (h_rd == d2);
    sts.cr_more   = ({1'b0, k} + (CNTW+1)'(1)) < {1'b0, rec_cnt};
    sts.rp_stop   = rp_stop;
    sts.rp_done   = (k == CNTW'(1));
    sts.nc_zero   = (nc == '0);
    sts.last_cand = ({1'b0, ci} + NCW'(1)) == nc;
    sts.seq_stop  = seq_stop;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      valid         <= '0;
      rp            <= '0;
      fcnt          <= '0;
      pend_v        <= 1'b0;
      result_strobe <= 1'b0;
      seq_degree    <= dcp_pkg::DEGW'(1);
      max_addr      <= '1;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          dcp_pkg::REG_SEQ_DEGREE:  seq_degree <= cfg_data[dcp_pkg::DEGW-1:0];
          dcp_pkg::REG_MAX_ADDRESS: max_addr <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == dcp_pkg::OP_MISS) begin
        valid[rp] <= 1'b1;
        rp <= (rp == EW'(TABLE_ENTRIES - 1)) ? '0 : rp + EW'(1);
      end
      if (ins_en) begin
        if (fcnt < FCW'(FILTER_DEPTH)) fcnt <= fcnt + FCW'(1);
      end else if (rm_en) begin
        fcnt <= fcnt - FCW'(1);
      end
      if (emit_en) begin
        pend_v <= 1'b1;
        if (pend_v) result_strobe <= 1'b1;
      end else if (cmd.op == dcp_pkg::OP_WB_FIN) begin
        pend_v        <= 1'b0;
        result_strobe <= 1'b1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      pend_a <= emit_addr;
      result <= '{prefetch_valid: 1'b1, prefetch_address: pend_a, last_of_run: 1'b0};
    end else if (cmd.op == dcp_pkg::OP_WB_FIN) begin
      result <= '{prefetch_valid: pend_v, prefetch_address: pend_v ? pend_a : '0,
                  last_of_run: 1'b1};
    end
    if (ins_en) begin
      for (int j = FILTER_DEPTH - 1; j > 0; j--) filt[j] <= filt[j-1];
      filt[0] <= ins_blk;
    end else if (rm_en) begin
      for (int j = 0; j < FILTER_DEPTH - 1; j++) begin
        if (FIW'(j) >= rm_idx) filt[j] <= filt[j+1];
      end
    end
    unique case (cmd.op)
      dcp_pkg::OP_LOAD: begin
        item_q <= item;
        idx    <= '0;
        nc     <= '0;
        ci     <= '0;
        p      <= item.access_address;
        sk     <= '0;
      end
      dcp_pkg::OP_SCMP: begin
        if (sts.srch_hit) begin
          eidx     <= idx;
          rec_tag  <= ent_tag;
          rec_last <= ent_last;
          rec_lpf  <= ent_lpf;
          rec_wp   <= ent_wp;
          rec_cnt  <= ent_cnt;
        end else if (!sts.srch_last) begin
          idx <= idx + EW'(1);
        end
      end
      dcp_pkg::OP_MISS: begin
        eidx     <= rp;
        rec_tag  <= item_q.instruction_address;
        rec_last <= item_q.access_address;
        rec_lpf  <= '0;
        rec_wp   <= '0;
        rec_cnt  <= '0;
      end
      dcp_pkg::OP_HIT: begin
        rec_last <= item_q.access_address;
        if (diff != '0) begin
          if (in_range) begin
            rec_wp <= wp_inc;
            if (rec_cnt < CNTW'(DELTAS_PER_ENTRY)) rec_cnt <= rec_cnt + CNTW'(1);
          end else begin
            rec_wp  <= '0;
            rec_cnt <= '0;
          end
        end
      end
      dcp_pkg::OP_CINIT: k <= '0;
      dcp_pkg::OP_CCMP: begin
        if (k == CNTW'(0)) d1 <= h_rd;
        if (k == CNTW'(1)) d2 <= h_rd;
        prev <= h_rd;
        if (sts.cr_match) begin
          k  <= k - CNTW'(1);
          ra <= rec_last;
        end else begin
          k <= k + CNTW'(1);
        end
      end
      dcp_pkg::OP_RSTEP: begin
        k <= k - CNTW'(1);
        if (!rp_stop) begin
          ra <= r_new;
          if (!dup && (nc < NCW'(dcp_pkg::MAX_CAND))) begin
            cand[nc[CANDW-1:0]] <= r_new;
            nc <= nc + NCW'(1);
          end
        end
      end
      dcp_pkg::OP_ISSUE: begin
        if (iss_ok) rec_lpf <= c_cur;
        ci <= ci + CANDW'(1);
      end
      dcp_pkg::OP_SEQ: begin
        if (!seq_stop) begin
          p  <= seq_new;
          sk <= sk + dcp_pkg::DEGW'(1);
        end
      end
      default: ;
    endcase
  end

endmodule
